// ----- rtl/vcil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcil_pkg
// Shared constants of the vehicle control input limiter: default value width,
// register indexes, opcodes, reset values and divider stage grouping.
// ----------------------------------------------------------------------------
package vcil_pkg;

	// default fixed-point value width (Q12.12)
	localparam int VALUE_WIDTH_DEF = 24;

	// quotient bits resolved in one divider stage
	localparam int DIV_BITS_PER_STAGE = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_VEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEC    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 3'd7;

	// command kinds
	localparam logic OP_STANDARD = 1'b0;
	localparam logic OP_LEGACY   = 1'b1;

	// register reset values
	localparam int RST_SWITCH_VEL = 29979;
	localparam int RST_MAX_VEL    = 81920;
	localparam int RST_MAX_ACC    = 38953;
	localparam int RST_MAX_DEC    = 38953;
	localparam int RST_MIN_ANGLE  = -1716;
	localparam int RST_MAX_ANGLE  = 1716;
	localparam int RST_MIN_RATE   = -13107;
	localparam int RST_MAX_RATE   = 13107;

endpackage

// ----- rtl/vcil_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcil_div
// Pipelined unsigned restoring divider, a few quotient bits per stage, with a
// sideband word that travels alongside and an overflow flag for quotients that
// do not fit in VALUE_WIDTH bits.
// ----------------------------------------------------------------------------
module vcil_div #(
	parameter int VALUE_WIDTH = vcil_pkg::VALUE_WIDTH_DEF,
	parameter int SIDE_WIDTH  = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2*VALUE_WIDTH-1:0]   num,
	input  logic [VALUE_WIDTH-1:0]     den,
	input  logic [SIDE_WIDTH-1:0]      side_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [VALUE_WIDTH-1:0]     quo,
	output logic                       ovf,
	output logic [SIDE_WIDTH-1:0]      side_out
);
	import vcil_pkg::*;

	localparam int W   = VALUE_WIDTH;
	localparam int BPS = DIV_BITS_PER_STAGE;
	localparam int ND  = (W + BPS - 1) / BPS;

	logic [ND-1:0]         v_q;
	logic [ND:0]           en;
	logic [W-1:0]          r_q    [ND];
	logic [W-1:0]          n_q    [ND];
	logic [W-1:0]          q_q    [ND];
	logic [W-1:0]          d_q    [ND];
	logic                  ovf_q  [ND];
	logic [SIDE_WIDTH-1:0] side_q [ND];

	assign en[ND] = ~out_stall;

	for (genvar k = 0; k < ND; k++) begin : g_stage
		logic                  v_in;
		logic [W-1:0]          r_in;
		logic [W-1:0]          n_in;
		logic [W-1:0]          q_in;
		logic [W-1:0]          d_in;
		logic                  ovf_in;
		logic [SIDE_WIDTH-1:0] side_in_k;
		logic [W:0]            rr;
		logic [W-1:0]          nn;
		logic [W-1:0]          qq;

		if (k == 0) begin : g_first
			assign v_in      = in_valid;
			assign r_in      = num[2*W-1:W];
			assign n_in      = num[W-1:0];
			assign q_in      = '0;
			assign d_in      = den;
			// high half not below divisor: quotient needs more than W bits
			assign ovf_in    = (num[2*W-1:W] >= den);
			assign side_in_k = side_in;
		end else begin : g_next
			assign v_in      = v_q[k-1];
			assign r_in      = r_q[k-1];
			assign n_in      = n_q[k-1];
			assign q_in      = q_q[k-1];
			assign d_in      = d_q[k-1];
			assign ovf_in    = ovf_q[k-1];
			assign side_in_k = side_q[k-1];
		end

		assign en[k] = ~v_q[k] | en[k+1];

		// shift in one dividend bit, trial subtract, shift in one quotient bit
		always_comb begin
			rr = {1'b0, r_in};
			nn = n_in;
			qq = q_in;
			for (int b = 0; b < BPS; b++) begin
				if (k * BPS + b < W) begin
					rr = {rr[W-1:0], nn[W-1]};
					nn = {nn[W-2:0], 1'b0};
					if (rr >= {1'b0, d_in}) begin
						rr = rr - {1'b0, d_in};
						qq = {qq[W-2:0], 1'b1};
					end else begin
						qq = {qq[W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				r_q[k]    <= rr[W-1:0];
				n_q[k]    <= nn;
				q_q[k]    <= qq;
				d_q[k]    <= d_in;
				ovf_q[k]  <= ovf_in;
				side_q[k] <= side_in_k;
			end
		end
	end

	assign in_stall  = ~en[0];
	assign out_valid = v_q[ND-1];
	assign quo       = q_q[ND-1];
	assign ovf       = ovf_q[ND-1];
	assign side_out  = side_q[ND-1];

endmodule

// ----- rtl/vehicle_control_input_limiter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_control_input_limiter_top
// Clamps standard commands (acceleration, steering velocity) to the vehicle
// limits and converts legacy setpoint commands into standard ones.
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------
// in       | sink      | in_valid / in_stall   | opcode, command_a, command_b,
//          |           |                       | current_velocity,
//          |           |                       | current_steer_angle
// out      | source    | out_valid / out_stall | accel_out, steer_rate_out,
//          |           |                       | modified
// cfg      | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one beat enters per cycle unless out_stall backs the pipe up; the divider
// resolves four quotient bits a stage; every stage holds on its own: a bubble
// is filled even while out_stall is high; arst_n clears the valid bits and
// loads the register reset values; cfg_ready is always high: the user, not
// the block, sees that registers are written only while the pipe is empty
// ----------------------------------------------------------------------------
module vehicle_control_input_limiter_top #(
	parameter int VALUE_WIDTH = vcil_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command beats
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic signed [VALUE_WIDTH-1:0]   command_a,
	input  logic signed [VALUE_WIDTH-1:0]   command_b,
	input  logic signed [VALUE_WIDTH-1:0]   current_velocity,
	input  logic signed [VALUE_WIDTH-1:0]   current_steer_angle,
	// result beats
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [VALUE_WIDTH-1:0]   accel_out,
	output logic signed [VALUE_WIDTH-1:0]   steer_rate_out,
	output logic                            modified,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vcil_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [VALUE_WIDTH-1:0]          cfg_data
);
	import vcil_pkg::*;

	localparam int W = VALUE_WIDTH;

	// per-item decisions that ride along with the divider
	typedef struct packed {
		logic                 legacy;     // legacy setpoint conversion
		logic signed [W-1:0]  ca;         // original acceleration command
		logic                 use_const;  // acceleration is acc_const
		logic signed [W-1:0]  acc_const;  // 0, -max_dec or +max_dec
		logic                 thr_div;    // threshold comes from the quotient
		logic                 neg;        // legacy velocity error negative
		logic signed [W-1:0]  rate;       // final steering velocity
		logic                 rate_mod;   // steering velocity was changed
	} side_t;

	localparam int SW = $bits(side_t);

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic [W-2:0]        switch_vel_q;
	logic [W-2:0]        max_vel_q;
	logic [W-2:0]        max_acc_q;
	logic [W-2:0]        max_dec_q;
	logic signed [W-1:0] min_angle_q;
	logic [W-2:0]        max_angle_q;
	logic signed [W-1:0] min_rate_q;
	logic [W-2:0]        max_rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_vel_q <= (W-1)'(RST_SWITCH_VEL);
			max_vel_q    <= (W-1)'(RST_MAX_VEL);
			max_acc_q    <= (W-1)'(RST_MAX_ACC);
			max_dec_q    <= (W-1)'(RST_MAX_DEC);
			min_angle_q  <= W'(RST_MIN_ANGLE);
			max_angle_q  <= (W-1)'(RST_MAX_ANGLE);
			min_rate_q   <= W'(RST_MIN_RATE);
			max_rate_q   <= (W-1)'(RST_MAX_RATE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SWITCH_VEL: switch_vel_q <= cfg_data[W-2:0];
				REG_MAX_VEL:    max_vel_q    <= cfg_data[W-2:0];
				REG_MAX_ACC:    max_acc_q    <= cfg_data[W-2:0];
				REG_MAX_DEC:    max_dec_q    <= cfg_data[W-2:0];
				REG_MIN_ANGLE:  min_angle_q  <= cfg_data;
				REG_MAX_ANGLE:  max_angle_q  <= cfg_data[W-2:0];
				REG_MIN_RATE:   min_rate_q   <= cfg_data;
				REG_MAX_RATE:   max_rate_q   <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// stage 1: compares, steering result, velocity error, divider operands
	// ------------------------------------------------------------------------
	logic signed [W:0]   ca_x, cb_x, vel_x, ang_x;
	logic signed [W:0]   sv_x, maxv_x, dec_x, maxang_x;
	logic signed [W:0]   e_x, serr_x;
	logic [W:0]          e_mag;
	logic                thr_div, rev_hit, dec_hit, stop_hit;
	logic                vel_pos, vel_neg, e_pos;
	logic signed [W-1:0] rate_std, rate_leg;
	logic signed [W-1:0] neg_dec, pos_dec;
	side_t               side_d;
	logic [W:0]          mul_b_d;
	logic [W-1:0]        den_d;

	logic                v_s1, v_s2;
	logic                en_s1, en_s2, en_out;
	side_t               side_s1, side_s2;
	logic [W:0]          mul_b_s1;
	logic [W-1:0]        den_s1, den_s2;
	logic [2*W-1:0]      num_s2;

	always_comb begin
		ca_x     = {command_a[W-1], command_a};
		cb_x     = {command_b[W-1], command_b};
		vel_x    = {current_velocity[W-1], current_velocity};
		ang_x    = {current_steer_angle[W-1], current_steer_angle};
		sv_x     = {2'b00, switch_vel_q};
		maxv_x   = {2'b00, max_vel_q};
		dec_x    = {2'b00, max_dec_q};
		maxang_x = {2'b00, max_angle_q};
		neg_dec  = -$signed({1'b0, max_dec_q});
		pos_dec  = $signed({1'b0, max_dec_q});

		// standard acceleration decisions
		thr_div = (vel_x > sv_x);
		rev_hit = (vel_x <= -maxv_x) && !command_a[W-1];
		dec_hit = (ca_x <= -dec_x);

		// standard steering: zero at the stops, else clamp, lower bound first
		stop_hit = ((current_steer_angle <= min_angle_q) && (command_b <= 0)) ||
			((ang_x >= maxang_x) && !command_b[W-1]);
		priority if (stop_hit) begin
			rate_std = '0;
		end else if (command_b <= min_rate_q) begin
			rate_std = min_rate_q;
		end else if (cb_x >= $signed({2'b00, max_rate_q})) begin
			rate_std = $signed({1'b0, max_rate_q});
		end else begin
			rate_std = command_b;
		end

		// legacy steering: bang-bang on the angle error
		serr_x = cb_x - ang_x;
		priority if (serr_x > 0) begin
			rate_leg = $signed({1'b0, max_rate_q});
		end else if (serr_x < 0) begin
			rate_leg = min_rate_q;
		end else begin
			rate_leg = '0;
		end

		// legacy velocity error and its sign tests
		e_x     = ca_x - vel_x;
		e_mag   = e_x[W] ? W'(0) - e_x : e_x;
		e_pos   = !e_x[W] && (e_x != 0);
		vel_pos = !current_velocity[W-1] && (current_velocity != 0);
		vel_neg = current_velocity[W-1];

		side_d.ca       = command_a;
		side_d.thr_div  = thr_div;
		side_d.neg      = e_x[W];
		if (opcode == OP_LEGACY) begin
			side_d.legacy   = 1'b1;
			side_d.rate     = rate_leg;
			side_d.rate_mod = 1'b1;
			// braking or reverse push when the error points against motion
			side_d.use_const = (vel_pos && !e_pos) || (vel_neg && e_pos);
			side_d.acc_const = vel_pos ? neg_dec : pos_dec;
			mul_b_d = e_mag;
			// zero gain divisor is taken as one lsb
			den_d   = (max_vel_q == '0) ? W'(1) : {1'b0, max_vel_q};
		end else begin
			side_d.legacy    = 1'b0;
			side_d.rate      = rate_std;
			side_d.rate_mod  = (rate_std != command_b);
			side_d.use_const = rev_hit || dec_hit;
			side_d.acc_const = rev_hit ? W'(0) : neg_dec;
			mul_b_d = {2'b00, switch_vel_q};
			// only used when velocity is above the switching velocity
			den_d   = current_velocity;
		end
	end

	// per-stage hold: a stage loads when empty or when its successor moves
	assign en_s1    = ~v_s1 | en_s2;
	assign in_stall = ~en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1  <= side_d;
			mul_b_s1 <= mul_b_d;
			den_s1   <= den_d;
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: dividend = max_acc * switching velocity, or 2 * max_acc * |e|
	// ------------------------------------------------------------------------
	logic [2*W-1:0] prod;
	logic           div_in_stall;

	assign prod  = {{(W+1){1'b0}}, max_acc_q} * {{(W-1){1'b0}}, mul_b_s1};
	assign en_s2 = ~v_s2 | ~div_in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			side_s2 <= side_s1;
			den_s2  <= den_s1;
			num_s2  <= side_s1.legacy ? {prod[2*W-2:0], 1'b0} : prod;
		end
	end

	// ------------------------------------------------------------------------
	// divider stages
	// ------------------------------------------------------------------------
	logic           div_valid;
	logic [W-1:0]   div_q;
	logic           div_ovf;
	logic [SW-1:0]  div_side;
	side_t          side_dv;

	vcil_div #(
		.VALUE_WIDTH (W),
		.SIDE_WIDTH  (SW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_stall  (div_in_stall),
		.num       (num_s2),
		.den       (den_s2),
		.side_in   (side_s2),
		.out_valid (div_valid),
		.out_stall (~en_out),
		.quo       (div_q),
		.ovf       (div_ovf),
		.side_out  (div_side)
	);

	assign side_dv = side_t'(div_side);

	// ------------------------------------------------------------------------
	// output stage: threshold clamp, saturated proportional term, flag
	// ------------------------------------------------------------------------
	logic signed [W-1:0] thr, acc_std, prop, acc_fin;
	logic [W-1:0]        q_neg;
	logic                prop_sat_lo, prop_sat_hi;
	logic                mod_d;

	always_comb begin
		thr     = side_dv.thr_div ? $signed(div_q) : $signed({1'b0, max_acc_q});
		acc_std = side_dv.use_const ? side_dv.acc_const :
			((side_dv.ca >= thr) ? thr : side_dv.ca);

		// quotient magnitude beyond the signed range saturates
		q_neg       = ~div_q + 1'b1;
		prop_sat_lo = div_ovf || (div_q[W-1] && (div_q[W-2:0] != '0));
		prop_sat_hi = div_ovf || div_q[W-1];
		if (side_dv.neg) begin
			prop = prop_sat_lo ? $signed({1'b1, {(W-1){1'b0}}}) : $signed(q_neg);
		end else begin
			prop = prop_sat_hi ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(div_q);
		end

		if (side_dv.legacy) begin
			acc_fin = side_dv.use_const ? side_dv.acc_const : prop;
			mod_d   = 1'b1;
		end else begin
			acc_fin = acc_std;
			mod_d   = (acc_std != side_dv.ca) || side_dv.rate_mod;
		end
	end

	assign en_out = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			accel_out      <= acc_fin;
			steer_rate_out <= side_dv.rate;
			modified       <= mod_d;
		end
	end

endmodule

// ----- tb/sv/vcil_limit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcil_limit_checker
// Watches the command, result and register channels of the limiter. Keeps
// its own copy of the limits, predicts the result of every accepted command
// and compares each accepted result field by field, oldest first.
// ----------------------------------------------------------------------------
module vcil_limit_checker #(
	parameter int W = vcil_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           opcode,
	input  logic signed [W-1:0]            command_a,
	input  logic signed [W-1:0]            command_b,
	input  logic signed [W-1:0]            current_velocity,
	input  logic signed [W-1:0]            current_steer_angle,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic signed [W-1:0]            accel_out,
	input  logic signed [W-1:0]            steer_rate_out,
	input  logic                           modified,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [vcil_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]                   cfg_data,
	output int                             fail_count,
	output int                             pending
);

	localparam longint VAL_MAX = (longint'(1) << (W - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic signed [W-1:0] accel;
		logic signed [W-1:0] rate;
		logic                modified;
	} limited_command_t;

	limited_command_t limited_queue[$];

	longint switch_vel;
	longint max_vel;
	longint max_acc;
	longint max_dec;
	longint min_angle;
	longint max_angle;
	longint min_rate;
	longint max_rate;
	int     errors;

	function automatic longint saturate(input longint x);
		longint v;
		v = x;
		if (x > VAL_MAX)
			v = VAL_MAX;
		else if (x < VAL_MIN)
			v = VAL_MIN;
		return v;
	endfunction

	function automatic limited_command_t limit_command(input logic op, input longint ca,
			input longint cb, input longint vel, input longint ang);
		limited_command_t r;
		longint thr;
		longint acc;
		longint rate;
		longint verr;
		longint divisor;
		longint prop;
		if (op == vcil_pkg::OP_STANDARD) begin
			// acceleration threshold falls inversely above the switching speed
			thr = max_acc;
			if (vel > switch_vel)
				thr = (max_acc * switch_vel) / vel;
			if (vel <= -max_vel && ca >= 0)
				acc = 0;
			else if (ca <= -max_dec)
				acc = -max_dec;
			else if (ca >= thr)
				acc = thr;
			else
				acc = ca;
			if ((ang <= min_angle && cb <= 0) || (ang >= max_angle && cb >= 0))
				rate = 0;
			else if (cb <= min_rate)
				rate = min_rate;
			else if (cb >= max_rate)
				rate = max_rate;
			else
				rate = cb;
			acc = saturate(acc);
			rate = saturate(rate);
			r.modified = (acc != ca) || (rate != cb);
		end else begin
			verr = ca - vel;
			divisor = (max_vel == 0) ? 1 : max_vel;
			prop = (2 * max_acc * verr) / divisor;
			if (cb > ang)
				rate = max_rate;
			else if (cb < ang)
				rate = min_rate;
			else
				rate = 0;
			if (vel > 0)
				acc = (verr > 0) ? prop : -max_dec;
			else if (vel < 0)
				acc = (verr > 0) ? max_dec : prop;
			else
				acc = prop;
			r.modified = 1'b1;
		end
		r.accel = saturate(acc);
		r.rate = saturate(rate);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		limited_command_t want;
		if (!arst_n) begin
			switch_vel = vcil_pkg::RST_SWITCH_VEL;
			max_vel    = vcil_pkg::RST_MAX_VEL;
			max_acc    = vcil_pkg::RST_MAX_ACC;
			max_dec    = vcil_pkg::RST_MAX_DEC;
			min_angle  = vcil_pkg::RST_MIN_ANGLE;
			max_angle  = vcil_pkg::RST_MAX_ANGLE;
			min_rate   = vcil_pkg::RST_MIN_RATE;
			max_rate   = vcil_pkg::RST_MAX_RATE;
			limited_queue.delete();
			errors = 0;
		end else begin
			// predict with the limits in force before any write at this edge
			if (in_valid && !in_stall)
				limited_queue.push_back(limit_command(opcode, command_a, command_b,
					current_velocity, current_steer_angle));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vcil_pkg::REG_SWITCH_VEL: switch_vel = cfg_data[W-2:0];
					vcil_pkg::REG_MAX_VEL:    max_vel    = cfg_data[W-2:0];
					vcil_pkg::REG_MAX_ACC:    max_acc    = cfg_data[W-2:0];
					vcil_pkg::REG_MAX_DEC:    max_dec    = cfg_data[W-2:0];
					vcil_pkg::REG_MIN_ANGLE:  min_angle  = $signed(cfg_data);
					vcil_pkg::REG_MAX_ANGLE:  max_angle  = cfg_data[W-2:0];
					vcil_pkg::REG_MIN_RATE:   min_rate   = $signed(cfg_data);
					vcil_pkg::REG_MAX_RATE:   max_rate   = cfg_data[W-2:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (limited_queue.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("[%0t] result beat with no command waiting: accel %0d rate %0d modified %0b",
							$time, accel_out, steer_rate_out, modified);
					errors++;
				end else begin
					want = limited_queue.pop_front();
					if (accel_out !== want.accel || steer_rate_out !== want.rate ||
							modified !== want.modified) begin
						if (errors < REPORT_LIMIT)
							$display("[%0t] mismatch: accel exp %0d got %0d, rate exp %0d got %0d, modified exp %0b got %0b",
								$time, want.accel, accel_out, want.rate, steer_rate_out,
								want.modified, modified);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending <= limited_queue.size();
	end

endmodule

// ----- tb/sv/vehicle_control_input_limiter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vehicle_control_input_limiter_top_tb
// Drives standard and legacy commands into the limiter under several limit
// settings, with random gaps on the command side and random stalls on the
// result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module vehicle_control_input_limiter_top_tb;

	localparam int     W              = vcil_pkg::VALUE_WIDTH_DEF;
	// depth of the whole pipe: stage 1, stage 2, divider stages, output register
	localparam int     PIPE_LATENCY   = 3 + (W + 3) / 4;
	localparam int     DRAIN_CYCLES   = 4 * PIPE_LATENCY;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     PHASE_COUNT    = 8;
	localparam int     PHASE_ITEMS    = 120;
	localparam longint VAL_MAX        = (longint'(1) << (W - 1)) - 1;
	localparam longint VAL_MIN        = -VAL_MAX - 1;
	localparam longint TOP_BIT        = longint'(1) << (W - 1);

	typedef struct {
		logic                op;
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
		logic signed [W-1:0] vel;
		logic signed [W-1:0] ang;
	} limiter_command_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic                           opcode;
	logic signed [W-1:0]            command_a;
	logic signed [W-1:0]            command_b;
	logic signed [W-1:0]            current_velocity;
	logic signed [W-1:0]            current_steer_angle;
	logic                           out_valid;
	logic                           out_stall;
	logic signed [W-1:0]            accel_out;
	logic signed [W-1:0]            steer_rate_out;
	logic                           modified;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [vcil_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [W-1:0]                   cfg_data;
	int                             fail_count;
	int                             pending;

	// effective limits as the block holds them, used to aim the stimulus
	longint lim_switch_vel;
	longint lim_max_vel;
	longint lim_max_acc;
	longint lim_max_dec;
	longint lim_min_angle;
	longint lim_max_angle;
	longint lim_min_rate;
	longint lim_max_rate;

	// burst modes: while set, that side neither idles nor stalls
	bit tx_burst;
	bit rx_burst;
	int items_sent;
	int results_taken;

	vehicle_control_input_limiter_top #(
		.VALUE_WIDTH(W)
	) i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.command_a          (command_a),
		.command_b          (command_b),
		.current_velocity   (current_velocity),
		.current_steer_angle(current_steer_angle),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accel_out          (accel_out),
		.steer_rate_out     (steer_rate_out),
		.modified           (modified),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	vcil_limit_checker #(
		.W(W)
	) i_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.command_a          (command_a),
		.command_b          (command_b),
		.current_velocity   (current_velocity),
		.current_steer_angle(current_steer_angle),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accel_out          (accel_out),
		.steer_rate_out     (steer_rate_out),
		.modified           (modified),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.fail_count         (fail_count),
		.pending            (pending)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// value a few lsb around a point of interest, the point itself included
	function automatic longint near_value(input longint center);
		longint offset;
		offset = $urandom_range(0, 6);
		return center + offset - 3;
	endfunction

	// mix of values near the limits, field extremes, full random bits and
	// values from random spans around zero
	function automatic longint pick_value(input longint c0, input longint c1,
			input longint c2);
		longint v;
		longint span;
		case ($urandom_range(0, 9))
			0, 1: v = near_value(c0);
			2, 3: v = near_value(c1);
			4:    v = near_value(c2);
			5: begin
				case ($urandom_range(0, 3))
					0:       v = VAL_MAX;
					1:       v = VAL_MIN;
					2:       v = 0;
					default: v = -1;
				endcase
			end
			6, 7: v = $urandom;
			default: begin
				span = longint'(1) << $urandom_range(2, 20);
				v = longint'($urandom_range(0, 2 * span)) - span;
			end
		endcase
		return v;
	endfunction

	function automatic limiter_command_t random_command();
		limiter_command_t c;
		c.op = ($urandom_range(0, 1) != 0) ? vcil_pkg::OP_LEGACY : vcil_pkg::OP_STANDARD;
		c.vel = pick_value(lim_switch_vel, -lim_max_vel, 0);
		c.ang = pick_value(lim_min_angle, lim_max_angle, 0);
		if (c.op == vcil_pkg::OP_STANDARD) begin
			c.a = pick_value(lim_max_acc, -lim_max_dec, 0);
			c.b = pick_value(lim_min_rate, lim_max_rate, 0);
		end else begin
			// setpoints close to the current state hit the zero-error cases
			c.a = ($urandom_range(0, 1) != 0) ? near_value(c.vel)
				: pick_value(lim_max_vel, -lim_max_vel, 0);
			c.b = ($urandom_range(0, 1) != 0) ? near_value(c.ang)
				: pick_value(lim_min_angle, lim_max_angle, 0);
		end
		return c;
	endfunction

	// one command beat; valid stays high into the next beat when no gap is drawn
	task automatic send_command(input limiter_command_t c);
		int gap;
		if (items_sent % 30 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid            <= 1'b1;
		opcode              <= c.op;
		command_a           <= c.a;
		command_b           <= c.b;
		current_velocity    <= c.vel;
		current_steer_angle <= c.ang;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic op, input longint a, input longint b,
			input longint vel, input longint ang);
		limiter_command_t c;
		c.op  = op;
		c.a   = a;
		c.b   = b;
		c.vel = vel;
		c.ang = ang;
		send_command(c);
	endtask

	task automatic write_reg(input logic [vcil_pkg::CFG_IDX_W-1:0] idx, input longint data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[W-1:0];
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
	endtask

	// writes all eight limits and keeps the values the block will hold
	task automatic apply_limits(input longint sv, input longint mv, input longint ma,
			input longint md, input longint mina, input longint maxa,
			input longint minr, input longint maxr);
		write_reg(vcil_pkg::REG_SWITCH_VEL, sv);
		write_reg(vcil_pkg::REG_MAX_VEL, mv);
		write_reg(vcil_pkg::REG_MAX_ACC, ma);
		write_reg(vcil_pkg::REG_MAX_DEC, md);
		write_reg(vcil_pkg::REG_MIN_ANGLE, mina);
		write_reg(vcil_pkg::REG_MAX_ANGLE, maxa);
		write_reg(vcil_pkg::REG_MIN_RATE, minr);
		write_reg(vcil_pkg::REG_MAX_RATE, maxr);
		cfg_valid <= 1'b0;
		// unsigned limits drop the top data bit, signed ones sign extend
		lim_switch_vel = sv[W-2:0];
		lim_max_vel    = mv[W-2:0];
		lim_max_acc    = ma[W-2:0];
		lim_max_dec    = md[W-2:0];
		lim_min_angle  = $signed(mina[W-1:0]);
		lim_max_angle  = maxa[W-2:0];
		lim_min_rate   = $signed(minr[W-1:0]);
		lim_max_rate   = maxr[W-2:0];
	endtask

	// pipe empty before any register write
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (PIPE_LATENCY) @(negedge clk);
	endtask

	// result side: random stall before each beat, or none while in burst mode
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		results_taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (results_taken % 40 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			hold = rx_burst ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			results_taken++;
			@(negedge clk);
		end
	end

	// ends the run when no channel has moved a beat for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int n;
		// every input known from time zero, reset held low at the start
		arst_n              = 1'b0;
		in_valid            = 1'b0;
		opcode              = vcil_pkg::OP_STANDARD;
		command_a           = '0;
		command_b           = '0;
		current_velocity    = '0;
		current_steer_angle = '0;
		cfg_valid           = 1'b0;
		cfg_index           = vcil_pkg::REG_SWITCH_VEL;
		cfg_data            = '0;
		items_sent          = 0;
		lim_switch_vel      = vcil_pkg::RST_SWITCH_VEL;
		lim_max_vel         = vcil_pkg::RST_MAX_VEL;
		lim_max_acc         = vcil_pkg::RST_MAX_ACC;
		lim_max_dec         = vcil_pkg::RST_MAX_DEC;
		lim_min_angle       = vcil_pkg::RST_MIN_ANGLE;
		lim_max_angle       = vcil_pkg::RST_MAX_ANGLE;
		lim_min_rate        = vcil_pkg::RST_MIN_RATE;
		lim_max_rate        = vcil_pkg::RST_MAX_RATE;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed commands against the reset limits
		// untouched command, then field extremes
		send_fields(vcil_pkg::OP_STANDARD, 0, 0, 0, 0);
		send_fields(vcil_pkg::OP_STANDARD, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
		send_fields(vcil_pkg::OP_STANDARD, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
		// reverse speed limit, at and just inside it
		send_fields(vcil_pkg::OP_STANDARD, 1000, 0, -vcil_pkg::RST_MAX_VEL, 0);
		send_fields(vcil_pkg::OP_STANDARD, 0, 0, 1 - vcil_pkg::RST_MAX_VEL, 0);
		// braking limit, at and beyond
		send_fields(vcil_pkg::OP_STANDARD, -vcil_pkg::RST_MAX_DEC, 0, 0, 0);
		send_fields(vcil_pkg::OP_STANDARD, -vcil_pkg::RST_MAX_DEC - 1, 0, 0, 0);
		// forward threshold, flat at the switching speed, scaled above it
		send_fields(vcil_pkg::OP_STANDARD, vcil_pkg::RST_MAX_ACC, 0, 0, 0);
		send_fields(vcil_pkg::OP_STANDARD, vcil_pkg::RST_MAX_ACC - 1, 0,
			vcil_pkg::RST_SWITCH_VEL, 0);
		send_fields(vcil_pkg::OP_STANDARD, vcil_pkg::RST_MAX_ACC, 0,
			vcil_pkg::RST_SWITCH_VEL + 1, 0);
		send_fields(vcil_pkg::OP_STANDARD, vcil_pkg::RST_MAX_ACC, 0,
			4 * vcil_pkg::RST_SWITCH_VEL, 0);
		// steering rate clamps and the angle stops
		send_fields(vcil_pkg::OP_STANDARD, 0, vcil_pkg::RST_MIN_RATE - 1, 0, 0);
		send_fields(vcil_pkg::OP_STANDARD, 0, vcil_pkg::RST_MAX_RATE + 1, 0, 0);
		send_fields(vcil_pkg::OP_STANDARD, 0, vcil_pkg::RST_MIN_RATE, 0,
			vcil_pkg::RST_MAX_ANGLE - 1);
		send_fields(vcil_pkg::OP_STANDARD, 0, 5, 0, vcil_pkg::RST_MAX_ANGLE);
		send_fields(vcil_pkg::OP_STANDARD, 0, -5, 0, vcil_pkg::RST_MAX_ANGLE);
		send_fields(vcil_pkg::OP_STANDARD, 0, -5, 0, vcil_pkg::RST_MIN_ANGLE);
		send_fields(vcil_pkg::OP_STANDARD, 0, 0, 0, vcil_pkg::RST_MIN_ANGLE);
		// legacy: each sign of velocity and of both errors, zero errors too
		send_fields(vcil_pkg::OP_LEGACY, 100000, 100, 50000, 0);
		send_fields(vcil_pkg::OP_LEGACY, 0, -100, 50000, 0);
		send_fields(vcil_pkg::OP_LEGACY, 0, 0, -50000, 0);
		send_fields(vcil_pkg::OP_LEGACY, -100000, 7, -50000, 7);
		send_fields(vcil_pkg::OP_LEGACY, 3, 0, 3, 0);
		send_fields(vcil_pkg::OP_LEGACY, VAL_MAX, VAL_MAX, 0, VAL_MIN);
		send_fields(vcil_pkg::OP_LEGACY, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX);

		// random commands under a series of limit settings
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_idle();
			case (phase)
				// reset values with the ignored top bit set on the unsigned limits
				0: apply_limits(vcil_pkg::RST_SWITCH_VEL | TOP_BIT,
					vcil_pkg::RST_MAX_VEL | TOP_BIT, vcil_pkg::RST_MAX_ACC | TOP_BIT,
					vcil_pkg::RST_MAX_DEC | TOP_BIT, vcil_pkg::RST_MIN_ANGLE,
					vcil_pkg::RST_MAX_ANGLE | TOP_BIT, vcil_pkg::RST_MIN_RATE,
					vcil_pkg::RST_MAX_RATE | TOP_BIT);
				// widest limits
				1: apply_limits(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MAX,
					VAL_MIN, VAL_MAX);
				// zero max velocity: legacy gain divides by one lsb and saturates
				2: apply_limits(0, 0, 5, 0, 0, 0, 0, 0);
				// inverted limits: positive lower stops above zero upper stops
				3: apply_limits(1, 1, 0, VAL_MAX, 100, 0, 50, 0);
				// arbitrary bits in every register
				7: apply_limits($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				// moderate limits in the range of a real vehicle
				default: apply_limits($urandom_range(0, 200000), $urandom_range(1, 200000),
					$urandom_range(0, 100000), $urandom_range(0, 100000),
					-longint'($urandom_range(0, 20000)), $urandom_range(0, 20000),
					-longint'($urandom_range(0, 50000)), $urandom_range(0, 50000));
			endcase
			if (phase == 2) begin
				// proportional term driven past both ends of the value range
				send_fields(vcil_pkg::OP_LEGACY, VAL_MAX, 0, 0, 0);
				send_fields(vcil_pkg::OP_LEGACY, VAL_MIN, 0, 0, 0);
				send_fields(vcil_pkg::OP_LEGACY, VAL_MIN, 0, -1, 0);
			end
			for (n = 0; n < PHASE_ITEMS; n++)
				send_command(random_command());
		end

		// drain, then give any stray beat time to show up
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/vcil_pkg.sv
rtl/vcil_div.sv
rtl/vehicle_control_input_limiter_top.sv
tb/sv/vcil_limit_checker.sv
tb/sv/vehicle_control_input_limiter_top_tb.sv
